@@ design/hss_pkg.sv @@
// Shared types, register codes and constants of the half-step stepper sequencer.
`default_nettype none

package hss_pkg;

  localparam int unsigned StepCountBits = 16;
  localparam int unsigned CfgIndexBits  = 3;
  localparam int unsigned CfgDataBits   = 16;

  localparam logic [7:0]  ResetDivider       = 8'd25;
  localparam logic [15:0] ResetArmLevel      = 16'hFFFF;
  localparam logic [15:0] ResetHomeWindow    = 16'd639;
  localparam logic [7:0]  ResetDebounceLimit = 8'd10;
  localparam logic [7:0]  DebounceMax        = 8'hFF;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_LOAD_A = 2'd1,
    REQ_LOAD_B = 2'd2
  } req_type_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_ACTIVE_AXIS    = 3'd0,
    CFG_DIVIDER_A      = 3'd1,
    CFG_DIVIDER_B      = 3'd2,
    CFG_ARM_LEVEL_A    = 3'd3,
    CFG_ARM_LEVEL_B    = 3'd4,
    CFG_HOME_WINDOW    = 3'd5,
    CFG_DEBOUNCE_LIMIT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [StepCountBits-1:0] step_count;
    logic                     sensor_a;
    logic                     sensor_b;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               coils;
    logic [StepCountBits-1:0] remaining_a;
    logic [StepCountBits-1:0] remaining_b;
    logic                     stepped;
    logic                     home_event;
  } out_item_t;

  typedef struct packed {
    logic        active_axis;
    logic [7:0]  divider_a;
    logic [7:0]  divider_b;
    logic [15:0] arm_level_a;
    logic [15:0] arm_level_b;
    logic [15:0] home_window;
    logic [7:0]  debounce_limit;
  } cfg_t;

  // half-step coil sequence, indexed by the low three count bits
  function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
    logic [3:0] c;
    case (phase)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/hss_cfg.sv @@
// Configuration register bank of the half-step stepper sequencer.
`default_nettype none

module hss_cfg import hss_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_en_i,
  input  wire logic [CfgIndexBits-1:0] wr_index_i,
  input  wire logic [CfgDataBits-1:0]  wr_data_i,
  output cfg_t                         cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_ACTIVE_AXIS:    cfg_d.active_axis    = wr_data_i[0];
        CFG_DIVIDER_A:      cfg_d.divider_a      = wr_data_i[7:0];
        CFG_DIVIDER_B:      cfg_d.divider_b      = wr_data_i[7:0];
        CFG_ARM_LEVEL_A:    cfg_d.arm_level_a    = wr_data_i[15:0];
        CFG_ARM_LEVEL_B:    cfg_d.arm_level_b    = wr_data_i[15:0];
        CFG_HOME_WINDOW:    cfg_d.home_window    = wr_data_i[15:0];
        CFG_DEBOUNCE_LIMIT: cfg_d.debounce_limit = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_axis    <= 1'b0;
      cfg_q.divider_a      <= ResetDivider;
      cfg_q.divider_b      <= ResetDivider;
      cfg_q.arm_level_a    <= ResetArmLevel;
      cfg_q.arm_level_b    <= ResetArmLevel;
      cfg_q.home_window    <= ResetHomeWindow;
      cfg_q.debounce_limit <= ResetDebounceLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/hss_step.sv @@
// Axis state and single-pass step evaluation of the half-step stepper sequencer.
`default_nettype none

module hss_step import hss_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output out_item_t     result_o
);

  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned WW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [CW-1:0] LowMask = CW'(7);
  localparam logic [CW-1:0] CntOne  = CW'(1);

  logic [7:0]    tick_q, tick_d;
  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [7:0]    deb_a_q, deb_a_d, deb_b_q, deb_b_d;
  logic [3:0]    coil_q, coil_d;

  logic          axis_b;
  logic [7:0]    tick_inc, div;
  logic          do_step;
  logic [CW-1:0] sel_cnt, cnt_dec, cnt_new, snapped, win_cw, load_cw;
  logic [WW-1:0] cnt_ext;
  logic [3:0]    step_coils;
  logic          armed, sensor, hit;
  logic [7:0]    deb, deb_inc, deb_new;

  always_comb begin
    axis_b   = cfg_i.active_axis;
    tick_inc = tick_q + 8'd1;
    div      = axis_b ? cfg_i.divider_b : cfg_i.divider_a;
    do_step  = (req_type_e'(item_i.req_type) == REQ_TICK) && (tick_inc >= div);
    load_cw  = CW'(item_i.step_count);

    sel_cnt = axis_b ? cnt_b_q : cnt_a_q;
    if (sel_cnt != '0) begin
      step_coils = half_step_coils(sel_cnt[2:0]);
      cnt_dec    = sel_cnt - CntOne;
    end else begin
      step_coils = 4'h0;
      cnt_dec    = '0;
    end

    cnt_ext = WW'(cnt_dec);
    if (axis_b) begin
      armed = cnt_ext < WW'(cfg_i.arm_level_b);
    end else begin
      armed = (cnt_ext < WW'(cfg_i.arm_level_a)) && (cnt_ext > WW'(cfg_i.home_window));
    end
    sensor  = axis_b ? item_i.sensor_b : item_i.sensor_a;
    deb     = axis_b ? deb_b_q : deb_a_q;
    deb_inc = (deb == DebounceMax) ? DebounceMax : deb + 8'd1;
    hit     = armed && sensor && (deb_inc > cfg_i.debounce_limit);

    if (!armed) begin
      deb_new = deb;
    end else if (sensor) begin
      deb_new = (hit && !axis_b) ? 8'd0 : deb_inc;
    end else begin
      deb_new = (deb != 8'd0) ? deb - 8'd1 : 8'd0;
    end

    win_cw  = CW'(cfg_i.home_window);
    snapped = win_cw & (cnt_dec | ~LowMask);
    if (axis_b) begin
      cnt_new = hit ? '0 : cnt_dec;
    end else begin
      cnt_new = hit ? snapped : cnt_dec;
    end

    tick_d  = tick_q;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    deb_a_d = deb_a_q;
    deb_b_d = deb_b_q;
    coil_d  = coil_q;
    case (req_type_e'(item_i.req_type))
      REQ_TICK: begin
        tick_d = do_step ? 8'd0 : tick_inc;
        if (do_step) begin
          coil_d = (hit && axis_b) ? 4'h0 : step_coils;
          if (axis_b) begin
            cnt_b_d = cnt_new;
            deb_b_d = deb_new;
          end else begin
            cnt_a_d = cnt_new;
            deb_a_d = deb_new;
          end
        end
      end
      REQ_LOAD_A: cnt_a_d = load_cw;
      REQ_LOAD_B: cnt_b_d = load_cw;
      default: ;
    endcase

    result_o.coils       = coil_d;
    result_o.remaining_a = StepCountBits'(cnt_a_d);
    result_o.remaining_b = StepCountBits'(cnt_b_d);
    result_o.stepped     = do_step;
    result_o.home_event  = do_step && hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      deb_a_q <= '0;
      deb_b_q <= '0;
      coil_q  <= '0;
    end else if (fire_i) begin
      tick_q  <= tick_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      deb_a_q <= deb_a_d;
      deb_b_q <= deb_b_d;
      coil_q  <= coil_d;
    end
  end

endmodule

`default_nettype wire

@@ design/half_step_stepper_sequencer_top.sv @@
// Top level of the half-step stepper sequencer: input register, step logic, result register.
//
//  channel  direction  handshake                  payload
//  in       in         in_valid_i / in_ready_o    in_item_i   (in_item_t)
//  out      out        out_valid_o / out_ready_i  out_item_o  (out_item_t)
//  cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item is held in the input register and is evaluated as it moves into
// the result register, which presents its result on the out channel.
// Sustained rate is one item per cycle while the result consumer keeps out_ready_i high.
// Reset clears all axis state and loads the register defaults; no clearing pass.
// A stalled result holds the result register; one more item waits in the input register.
`default_nettype none

module half_step_stepper_sequencer_top import hss_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire in_item_t                in_item_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output out_item_t                    out_item_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i
);

  logic      stage_v_q, stage_v_d;
  in_item_t  stage_q;
  logic      out_v_q, out_v_d;
  out_item_t out_q;
  out_item_t result;
  cfg_t      cfg;
  logic      out_free, fire, in_acc;

  assign out_free   = !out_v_q || out_ready_i;
  assign fire       = stage_v_q && out_free;
  assign in_ready_o = !stage_v_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign stage_v_d  = in_acc || (stage_v_q && !fire);
  assign out_v_d    = fire || (out_v_q && !out_ready_i);

  assign cfg_ready_o = 1'b1;

  hss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  hss_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stage_q <= in_item_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ design/hss_chk.sv @@
// Port-level checker of the half-step stepper sequencer, bound to the top level.
`default_nettype none

module hss_chk import hss_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // input only backs up behind a waiting result
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_home_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.home_event |-> out_item_o.stepped)
    else $error("home event without a step");

  a_coil_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.coils != 4'h5) && (out_item_o.coils != 4'h7) &&
                    (out_item_o.coils != 4'hA) && (out_item_o.coils != 4'hB) &&
                    (out_item_o.coils != 4'hD) && (out_item_o.coils != 4'hE) &&
                    (out_item_o.coils != 4'hF))
    else $error("coil drive outside the half-step sequence");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed or dropped");

endmodule

bind half_step_stepper_sequencer_top hss_chk u_hss_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the half-step stepper sequencer: directed, random and stall tests.
module tb_top;
  import hss_pkg::*;

  localparam logic [1:0]               ReqUnused = 2'd3;
  localparam logic [StepCountBits-1:0] SnapMask  = 16'hFFF8;
  localparam int unsigned              GapMax    = 12;

  logic clk = 1'b0;
  logic rst_n;

  logic                    in_valid;
  logic                    in_ready;
  in_item_t                in_item;
  logic                    out_valid;
  logic                    out_ready;
  out_item_t               out_item;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0]  cfg_data;

  // predicted block state and register copy
  cfg_t                     shadow_cfg;
  logic [7:0]               tick_cnt;
  logic [StepCountBits-1:0] cnt_a;
  logic [StepCountBits-1:0] cnt_b;
  logic [7:0]               deb_a;
  logic [7:0]               deb_b;
  logic [3:0]               coil_q;
  logic [3:0]               phase_coils [0:7] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  out_item_t   pending_outputs [$];
  int unsigned mismatches = 0;

  logic        src_idle  = 1'b0;
  logic        sink_idle = 1'b0;
  int unsigned sink_hold_cycles = 0;
  int unsigned sensor_flip_pct  = 10;
  logic        sense_a = 1'b0;
  logic        sense_b = 1'b0;

  half_step_stepper_sequencer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic cfg_t default_config();
    cfg_t c;
    c.active_axis    = 1'b0;
    c.divider_a      = ResetDivider;
    c.divider_b      = ResetDivider;
    c.arm_level_a    = ResetArmLevel;
    c.arm_level_b    = ResetArmLevel;
    c.home_window    = ResetHomeWindow;
    c.debounce_limit = ResetDebounceLimit;
    return c;
  endfunction

  // one half-step: coils from the count phase, then count down
  function automatic logic [StepCountBits-1:0] advance_count(input logic [StepCountBits-1:0] c);
    if (c != '0) begin
      coil_q = phase_coils[c[2:0]];
      return c - 1'b1;
    end
    coil_q = 4'h0;
    return c;
  endfunction

  function automatic logic step_axis_a(input logic sensor);
    cnt_a = advance_count(cnt_a);
    if (cnt_a < shadow_cfg.arm_level_a && cnt_a > shadow_cfg.home_window) begin
      if (sensor) begin
        if (deb_a != DebounceMax) deb_a = deb_a + 8'd1;
        if (deb_a > shadow_cfg.debounce_limit) begin
          cnt_a = shadow_cfg.home_window & (cnt_a | SnapMask);
          deb_a = 8'd0;
          return 1'b1;
        end
      end else if (deb_a != 8'd0) begin
        deb_a = deb_a - 8'd1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic step_axis_b(input logic sensor);
    cnt_b = advance_count(cnt_b);
    if (cnt_b < shadow_cfg.arm_level_b) begin
      if (sensor) begin
        if (deb_b != DebounceMax) deb_b = deb_b + 8'd1;
        if (deb_b > shadow_cfg.debounce_limit) begin
          cnt_b  = '0;
          coil_q = 4'h0;
          return 1'b1;
        end
      end else if (deb_b != 8'd0) begin
        deb_b = deb_b - 8'd1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_item_t sequencer_outputs(input in_item_t req);
    out_item_t  r;
    logic [7:0] div;
    logic       stepped;
    logic       home;
    stepped = 1'b0;
    home    = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        div      = shadow_cfg.active_axis ? shadow_cfg.divider_b : shadow_cfg.divider_a;
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= div) begin
          tick_cnt = 8'd0;
          stepped  = 1'b1;
          if (shadow_cfg.active_axis) home = step_axis_b(req.sensor_b);
          else home = step_axis_a(req.sensor_a);
        end
      end
      REQ_LOAD_A: cnt_a = req.step_count;
      REQ_LOAD_B: cnt_b = req.step_count;
      default: ;
    endcase
    r.coils       = coil_q;
    r.remaining_a = cnt_a;
    r.remaining_b = cnt_b;
    r.stepped     = stepped;
    r.home_event  = home;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("coils", 16'(want.coils), 16'(out_item.coils));
        check_field("remaining_a", want.remaining_a, out_item.remaining_a);
        check_field("remaining_b", want.remaining_b, out_item.remaining_b);
        check_field("stepped", 16'(want.stepped), 16'(out_item.stepped));
        check_field("home_event", 16'(want.home_event), 16'(out_item.home_event));
      end
    end
  end

  initial begin : result_sink
    int unsigned wait_cycles;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      wait_cycles      = sink_hold_cycles + (sink_idle ? $urandom_range(0, GapMax) : 0);
      sink_hold_cycles = 0;
      if (wait_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_item(input in_item_t req);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, GapMax) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_outputs.push_back(sequencer_outputs(req));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(CFG_ACTIVE_AXIS, {15'd0, c.active_axis});
    write_reg(CFG_DIVIDER_A, {8'd0, c.divider_a});
    write_reg(CFG_DIVIDER_B, {8'd0, c.divider_b});
    write_reg(CFG_ARM_LEVEL_A, c.arm_level_a);
    write_reg(CFG_ARM_LEVEL_B, c.arm_level_b);
    write_reg(CFG_HOME_WINDOW, c.home_window);
    write_reg(CFG_DEBOUNCE_LIMIT, {8'd0, c.debounce_limit});
    cfg_valid  <= 1'b0;
    shadow_cfg = c;
  endtask

  function automatic in_item_t make_request(input logic [1:0] kind,
                                            input logic [StepCountBits-1:0] count,
                                            input logic sa, input logic sb);
    in_item_t r;
    r.req_type   = kind;
    r.step_count = count;
    r.sensor_a   = sa;
    r.sensor_b   = sb;
    return r;
  endfunction

  function automatic logic [7:0] pick_divider();
    case ($urandom_range(0, 9))
      0: return 8'hFF;
      1: return 8'd0;
      2: return 8'd1;
      default: return 8'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 64));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.active_axis = 1'($urandom_range(0, 1));
    c.divider_a   = pick_divider();
    c.divider_b   = pick_divider();
    c.arm_level_a = pick_level();
    c.arm_level_b = pick_level();
    case ($urandom_range(0, 4))
      0: c.home_window = 16'h0000;
      1: c.home_window = 16'($urandom_range(0, 40));
      2: c.home_window = ResetHomeWindow;
      3: c.home_window = 16'hFFFF;
      default: c.home_window = 16'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0: c.debounce_limit = DebounceMax;
      1: c.debounce_limit = 8'($urandom_range(0, 255));
      default: c.debounce_limit = 8'($urandom_range(0, 4));
    endcase
    return c;
  endfunction

  function automatic logic [StepCountBits-1:0] random_count();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 24));
      1: return 16'hFFFF;
      2: return shadow_cfg.home_window + 16'($urandom_range(0, 24));
      3: return shadow_cfg.arm_level_a - 16'($urandom_range(0, 24));
      4: return shadow_cfg.arm_level_b - 16'($urandom_range(0, 8));
      default: return 16'($urandom());
    endcase
  endfunction

  // sensors change level now and then so debouncing gets long runs
  function automatic in_item_t random_request();
    logic [1:0]  kind;
    int unsigned pick;
    if ($urandom_range(0, 99) < sensor_flip_pct) sense_a = ~sense_a;
    if ($urandom_range(0, 99) < sensor_flip_pct) sense_b = ~sense_b;
    pick = $urandom_range(0, 99);
    if (pick < 72) kind = REQ_TICK;
    else if (pick < 84) kind = REQ_LOAD_A;
    else if (pick < 96) kind = REQ_LOAD_B;
    else kind = ReqUnused;
    return make_request(kind, random_count(), sense_a, sense_b);
  endfunction

  task automatic test_requests();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_item(make_request(REQ_LOAD_A, 16'hFFFF, 1'b1, 1'b1));
    send_item(make_request(REQ_LOAD_B, 16'h0000, 1'b0, 1'b0));
    send_item(make_request(ReqUnused, 16'hFFFF, 1'b1, 1'b0));
    send_item(make_request(REQ_LOAD_B, 16'h5A5A, 1'b0, 1'b1));
    send_item(make_request(REQ_TICK, 16'hFFFF, 1'b1, 1'b1));
    send_item(make_request(REQ_TICK, 16'h0000, 1'b0, 1'b0));
    wait_for_results();
  endtask

  task automatic test_axis_a_home();
    cfg_t c;
    c                = default_config();
    c.divider_a      = 8'd0;
    c.home_window    = 16'h0100;
    c.debounce_limit = 8'd1;
    apply_config(c);
    src_idle = 1'b1;
    send_item(make_request(REQ_LOAD_A, 16'h0107, 1'b0, 1'b0));
    repeat (3) send_item(make_request(REQ_TICK, 16'h0000, 1'b1, 1'b0));
    send_item(make_request(REQ_LOAD_A, 16'h0200, 1'b0, 1'b0));
    send_item(make_request(REQ_TICK, 16'h0000, 1'b1, 1'b0));
    send_item(make_request(REQ_TICK, 16'h0000, 1'b0, 1'b0));
    wait_for_results();
  endtask

  task automatic test_axis_b_home();
    cfg_t c;
    c                = default_config();
    c.active_axis    = 1'b1;
    c.divider_b      = 8'd1;
    c.arm_level_b    = 16'h0010;
    c.debounce_limit = 8'd0;
    apply_config(c);
    sink_idle = 1'b1;
    send_item(make_request(REQ_LOAD_B, 16'h0012, 1'b0, 1'b0));
    repeat (4) send_item(make_request(REQ_TICK, 16'hFFFF, 1'b0, 1'b1));
    send_item(make_request(REQ_TICK, 16'hFFFF, 1'b1, 1'b0));
    wait_for_results();
  endtask

  task automatic test_divider_lowered();
    cfg_t c;
    c           = default_config();
    c.divider_a = 8'hFF;
    apply_config(c);
    repeat (3) send_item(make_request(REQ_TICK, 16'h0000, 1'b0, 1'b0));
    wait_for_results();
    c.divider_a = 8'd2;
    apply_config(c);
    send_item(make_request(REQ_TICK, 16'h0000, 1'b0, 1'b0));
    wait_for_results();
  endtask

  task automatic test_back_pressure();
    cfg_t c;
    c           = random_config();
    c.divider_a = 8'd1;
    c.divider_b = 8'd1;
    apply_config(c);
    src_idle         = 1'b0;
    sink_idle        = 1'b0;
    sink_hold_cycles = 40;
    repeat (12) send_item(random_request());
    wait_for_results();
    repeat (12) send_item(random_request());
    wait_for_results();
  endtask

  task automatic test_random_phases();
    cfg_t        c;
    int unsigned n;
    for (int p = 0; p < 8; p++) begin
      c = random_config();
      apply_config(c);
      src_idle        = p[0];
      sink_idle       = p[1];
      sensor_flip_pct = $urandom_range(2, 40);
      n               = $urandom_range(20, 40);
      repeat (n) send_item(random_request());
      wait_for_results();
    end
  endtask

  // hold the active sensor for more than 255 steps, then drop the limit by one
  task automatic test_debounce_saturation();
    cfg_t c;
    c                = default_config();
    c.active_axis    = 1'($urandom_range(0, 1));
    c.divider_a      = 8'd0;
    c.divider_b      = 8'd0;
    c.home_window    = 16'h0000;
    c.debounce_limit = DebounceMax;
    apply_config(c);
    src_idle  = 1'($urandom_range(0, 1));
    sink_idle = 1'($urandom_range(0, 1));
    send_item(make_request(c.active_axis ? REQ_LOAD_B : REQ_LOAD_A, 16'hFFFF, 1'b1, 1'b1));
    repeat (260) send_item(make_request(REQ_TICK, 16'($urandom()), 1'b1, 1'b1));
    wait_for_results();
    c.debounce_limit = DebounceMax - 8'd1;
    apply_config(c);
    repeat (4) send_item(make_request(REQ_TICK, 16'($urandom()), 1'b1, 1'b1));
    wait_for_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    shadow_cfg = default_config();
    tick_cnt   = 8'd0;
    cnt_a      = '0;
    cnt_b      = '0;
    deb_a      = 8'd0;
    deb_b      = 8'd0;
    coil_q     = 4'h0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_requests();
    test_axis_a_home();
    test_axis_b_home();
    test_divider_lowered();
    test_back_pressure();
    test_random_phases();
    test_debounce_saturation();

    wait_for_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
